// ===== rtl/tmr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmr_pkg
// Shared codes, defaults and result word type for the timer slot table.
// ----------------------------------------------------------------------------
package tmr_pkg;

   localparam int TMR_SLOTS       = 16;
   localparam int TMR_TIME_BITS   = 31;
   localparam int TMR_OWNER_BITS  = 8;
   localparam int TMR_MAX_RESULTS = 16;

   localparam logic [2:0] CMD_SET       = 3'd0;
   localparam logic [2:0] CMD_CLEAR     = 3'd1;
   localparam logic [2:0] CMD_QUERY     = 3'd2;
   localparam logic [2:0] CMD_TICK      = 3'd3;
   localparam logic [2:0] CMD_CLR_OWNER = 3'd4;

   localparam logic [2:0] KIND_SET_ACK = 3'd0;
   localparam logic [2:0] KIND_CLR_ACK = 3'd1;
   localparam logic [2:0] KIND_QUERY   = 3'd2;
   localparam logic [2:0] KIND_FIRE    = 3'd3;
   localparam logic [2:0] KIND_NO_FIRE = 3'd4;

   typedef struct packed {
      logic               strobe;
      logic [2:0]         kind;
      logic [3:0]         out_slot;
      logic               out_handle_valid;
      logic               active;
      logic signed [31:0] remaining;
      logic [7:0]         fire_count;
      logic               no_free_slot;
      logic               last;
   } rsp_type;

endpackage

// ===== rtl/tmr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmr_div
// Restoring divider, one quotient bit per cycle, for multi-fire reloads.
// ----------------------------------------------------------------------------
module tmr_div #(
   parameter int W = 31
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quot,
   output logic [W-1:0] rem
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  quot_ff, quot_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [W:0]    shifted;
   logic [W:0]    trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quot_ff[W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      if (go) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(W);
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (!trial[W]) begin
            rem_in  = trial[W-1:0];
            quot_in = {quot_ff[W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[W-1:0];
            quot_in = {quot_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

// ===== rtl/multi_slot_software_timer_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_software_timer_table_unit
// Timer slot table: set, clear, query, tick and clear-by-owner commands.
// Set and clear answer in the cycle after start; a query reads the slot in S_QRY.
// Tick and clear-by-owner walk the slot memory through S_RD and S_EV per slot, then S_FIN,
// and a tick waits in S_DIV on the reload divider for each expired looping slot.
// One command at a time; busy is high through a query or a slot walk.
// Reset clears all slot valid flags at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_slot_software_timer_table_unit
   import tmr_pkg::*;
#(
   parameter int SLOTS      = TMR_SLOTS,
   parameter int TIME_BITS  = TMR_TIME_BITS,
   parameter int OWNER_BITS = TMR_OWNER_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_cmd,
   input  logic               req_handle_valid,
   input  logic [3:0]         req_slot,
   input  logic [7:0]         req_owner,
   input  logic [30:0]        req_rate,
   input  logic               req_looping,
   input  logic signed [31:0] req_first_delay,
   input  logic [30:0]        req_delta,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_kind,
   output logic [3:0]         rsp_out_slot,
   output logic               rsp_out_handle_valid,
   output logic               rsp_active,
   output logic signed [31:0] rsp_remaining,
   output logic [7:0]         rsp_fire_count,
   output logic               rsp_no_free_slot,
   output logic               rsp_last
);
   localparam int TB  = TIME_BITS;
   localparam int OB  = OWNER_BITS;
   localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int EW  = ((TB > 32) ? TB : 32) + 1;
   localparam int MW  = 1 + TB + TB + OB;
   localparam int CNW = $clog2(TMR_MAX_RESULTS + 1);
   // memory word fields
   localparam int OWN_LO = 0;
   localparam int LFT_LO = OB;
   localparam int PER_LO = OB + TB;
   localparam int LOOP_B = OB + 2 * TB;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_QRY  = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_EV   = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   localparam logic [EW-1:0] TMAX_EXT = (EW'(1) << TB) - EW'(1);

   logic [MW-1:0] mem [SLOTS];
   logic [MW-1:0] mem_q_ff;
   logic [SW-1:0] rd_addr;
   logic          mem_we;
   logic [SW-1:0] mem_wa;
   logic [MW-1:0] mem_wd;

   logic [SLOTS-1:0] used_ff, used_in;
   logic [2:0]       state_ff, state_in;
   logic [SW-1:0]    idx_ff, idx_in;
   logic [2:0]       cmd_ff, cmd_in;
   logic             hv_ff, hv_in;
   logic             named_ff, named_in;
   logic [3:0]       slot_ff, slot_in;
   logic [OB-1:0]    owner_ff, owner_in;
   logic [TB-1:0]    delta_ff, delta_in;
   logic [TB-1:0]    per_ff, per_in;
   logic [CNW-1:0]   cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic [3:0]       pslot_ff, pslot_in;
   logic             phv_ff, phv_in;
   logic [7:0]       pk_ff, pk_in;
   rsp_type          rsp_ff, rsp_in;

   logic [EW-1:0] rate_ext, fd_ext, delta_ext;
   logic [TB-1:0] rate_sat, fd_sat, delta_sat;
   logic [OB-1:0] req_own;
   logic [SW-1:0] req_idx;
   logic          req_named;
   logic          free_found;
   logic [SW-1:0] free_idx;

   logic [TB-1:0] m_left, m_per, p_eff;
   logic [OB-1:0] m_own;
   logic          m_loop;
   logic [EW-1:0] left_ext;

   logic          div_go, div_done;
   logic [TB-1:0] div_a, div_b, div_q, div_r;
   logic [7:0]    fire_k;

   logic          fire_now;
   logic [3:0]    fire_slot;
   logic          fire_hv;
   logic [7:0]    fire_cnt;

   tmr_div #(.W(TB)) u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quot     (div_q),
      .rem      (div_r)
   );

   // input conditioning
   always_comb begin
      rate_ext  = EW'(req_rate);
      fd_ext    = EW'(req_first_delay[30:0]);
      delta_ext = EW'(req_delta);
      rate_sat  = (rate_ext > TMAX_EXT) ? TMAX_EXT[TB-1:0] : rate_ext[TB-1:0];
      fd_sat    = (fd_ext > TMAX_EXT) ? TMAX_EXT[TB-1:0] : fd_ext[TB-1:0];
      delta_sat = (delta_ext > TMAX_EXT) ? TMAX_EXT[TB-1:0] : delta_ext[TB-1:0];
      req_own   = OB'(req_owner);
      req_idx   = SW'(req_slot);
      req_named = req_handle_valid && (32'(req_slot) < SLOTS);
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SW'(i);
         end
      end
   end

   always_comb begin
      m_loop   = mem_q_ff[LOOP_B];
      m_per    = mem_q_ff[PER_LO +: TB];
      m_left   = mem_q_ff[LFT_LO +: TB];
      m_own    = mem_q_ff[OWN_LO +: OB];
      p_eff    = (m_per == '0) ? TB'(1) : m_per;
      left_ext = EW'(m_left);
      fire_k   = (div_q >= TB'(255)) ? 8'd255 : (8'(div_q) + 8'd1);
   end

   assign rd_addr = (state_ff == S_IDLE) ? req_idx : idx_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      used_in  = used_ff;
      idx_in   = idx_ff;
      cmd_in   = cmd_ff;
      hv_in    = hv_ff;
      named_in = named_ff;
      slot_in  = slot_ff;
      owner_in = owner_ff;
      delta_in = delta_ff;
      per_in   = per_ff;
      cnt_in   = cnt_ff;
      pend_in  = pend_ff;
      pslot_in = pslot_ff;
      phv_in   = phv_ff;
      pk_in    = pk_ff;
      rsp_in   = '0;
      mem_we   = 1'b0;
      mem_wa   = idx_ff;
      mem_wd   = mem_q_ff;
      div_go   = 1'b0;
      div_a    = m_left;
      div_b    = p_eff;
      fire_now  = 1'b0;
      fire_slot = 4'(idx_ff);
      fire_hv   = 1'b0;
      fire_cnt  = 8'd1;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_cmd;
               hv_in    = req_handle_valid;
               named_in = req_named;
               slot_in  = req_slot;
               owner_in = req_own;
               delta_in = delta_sat;
               idx_in   = req_idx;
               cnt_in   = '0;
               pend_in  = 1'b0;
               case (req_cmd)
                  CMD_SET: begin
                     rsp_in.strobe = 1'b1;
                     rsp_in.kind   = KIND_SET_ACK;
                     rsp_in.last   = 1'b1;
                     if (rate_sat == '0) begin
                        if (req_named) begin
                           used_in[req_idx] = 1'b0;
                        end
                        rsp_in.out_slot = req_slot;
                     end else if (!req_named && !free_found) begin
                        rsp_in.no_free_slot = 1'b1;
                     end else begin
                        mem_we = 1'b1;
                        mem_wa = req_named ? req_idx : free_idx;
                        mem_wd = {req_looping, rate_sat,
                                  req_first_delay[31] ? rate_sat : fd_sat, req_own};
                        used_in[mem_wa]         = 1'b1;
                        rsp_in.out_slot         = 4'(mem_wa);
                        rsp_in.out_handle_valid = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     if (req_named) begin
                        used_in[req_idx] = 1'b0;
                     end
                     rsp_in.strobe   = 1'b1;
                     rsp_in.kind     = KIND_CLR_ACK;
                     rsp_in.out_slot = req_slot;
                     rsp_in.last     = 1'b1;
                  end
                  CMD_QUERY: begin
                     state_in = S_QRY;
                  end
                  CMD_TICK: begin
                     if (delta_sat == '0) begin
                        rsp_in.strobe = 1'b1;
                        rsp_in.kind   = KIND_NO_FIRE;
                        rsp_in.last   = 1'b1;
                     end else begin
                        idx_in   = '0;
                        state_in = S_RD;
                     end
                  end
                  CMD_CLR_OWNER: begin
                     if (req_own == '0) begin
                        rsp_in.strobe = 1'b1;
                        rsp_in.kind   = KIND_CLR_ACK;
                        rsp_in.last   = 1'b1;
                     end else begin
                        idx_in   = '0;
                        state_in = S_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_QRY: begin
            rsp_in.strobe           = 1'b1;
            rsp_in.kind             = KIND_QUERY;
            rsp_in.out_slot         = slot_ff;
            rsp_in.out_handle_valid = hv_ff;
            rsp_in.last             = 1'b1;
            if (named_ff && used_ff[idx_ff]) begin
               rsp_in.active    = 1'b1;
               rsp_in.remaining = (left_ext > EW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                                 : 32'(left_ext);
            end else begin
               rsp_in.remaining = -32'sd1;
            end
            state_in = S_IDLE;
         end
         S_RD: begin
            state_in = S_EV;
         end
         S_EV: begin
            state_in = S_RD;
            if (cmd_ff == CMD_CLR_OWNER) begin
               if (used_ff[idx_ff] && m_own == owner_ff) begin
                  used_in[idx_ff] = 1'b0;
               end
            end else if (used_ff[idx_ff]) begin
               if (m_left > delta_ff) begin
                  mem_we = 1'b1;
                  mem_wd = {m_loop, m_per, m_left - delta_ff, m_own};
               end else if (m_loop) begin
                  div_go   = 1'b1;
                  div_a    = delta_ff - m_left;
                  div_b    = p_eff;
                  per_in   = p_eff;
                  state_in = S_DIV;
               end else begin
                  used_in[idx_ff] = 1'b0;
                  fire_now        = 1'b1;
               end
            end
            if (state_in != S_DIV) begin
               if (idx_ff == SW'(SLOTS - 1)) begin
                  state_in = S_FIN;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               mem_we   = 1'b1;
               mem_wd   = {m_loop, m_per, per_ff - div_r, m_own};
               fire_now = 1'b1;
               fire_hv  = 1'b1;
               fire_cnt = fire_k;
               if (idx_ff == SW'(SLOTS - 1)) begin
                  state_in = S_FIN;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         S_FIN: begin
            rsp_in.strobe = 1'b1;
            rsp_in.last   = 1'b1;
            if (cmd_ff == CMD_CLR_OWNER) begin
               rsp_in.kind = KIND_CLR_ACK;
            end else if (pend_ff) begin
               rsp_in.kind             = KIND_FIRE;
               rsp_in.out_slot         = pslot_ff;
               rsp_in.out_handle_valid = phv_ff;
               rsp_in.fire_count       = pk_ff;
            end else begin
               rsp_in.kind = KIND_NO_FIRE;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a fire word is held back until the next fire or S_FIN so the final one can carry last
      if (fire_now && cnt_ff < CNW'(TMR_MAX_RESULTS)) begin
         if (pend_ff) begin
            rsp_in.strobe           = 1'b1;
            rsp_in.kind             = KIND_FIRE;
            rsp_in.out_slot         = pslot_ff;
            rsp_in.out_handle_valid = phv_ff;
            rsp_in.fire_count       = pk_ff;
         end
         pend_in  = 1'b1;
         pslot_in = fire_slot;
         phv_in   = fire_hv;
         pk_in    = fire_cnt;
         cnt_in   = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         rsp_ff   <= '0;
         pend_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         rsp_ff   <= rsp_in;
         pend_ff  <= pend_in;
         cnt_ff   <= cnt_in;
      end
      idx_ff   <= idx_in;
      cmd_ff   <= cmd_in;
      hv_ff    <= hv_in;
      named_ff <= named_in;
      slot_ff  <= slot_in;
      owner_ff <= owner_in;
      delta_ff <= delta_in;
      per_ff   <= per_in;
      pslot_ff <= pslot_in;
      phv_ff   <= phv_in;
      pk_ff    <= pk_in;
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_strobe           = rsp_ff.strobe;
   assign rsp_kind             = rsp_ff.kind;
   assign rsp_out_slot         = rsp_ff.out_slot;
   assign rsp_out_handle_valid = rsp_ff.out_handle_valid;
   assign rsp_active           = rsp_ff.active;
   assign rsp_remaining        = rsp_ff.remaining;
   assign rsp_fire_count       = rsp_ff.fire_count;
   assign rsp_no_free_slot     = rsp_ff.no_free_slot;
   assign rsp_last             = rsp_ff.last;

endmodule

// ===== dv/tb_multi_slot_software_timer_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_slot_software_timer_table_unit
// Self-checking bench for the timer slot table. Commands are driven through
// the start/busy handshake, a timer table model predicts every result word
// and a scoreboard compares each strobed word in order.
// ----------------------------------------------------------------------------
module tb_multi_slot_software_timer_table_unit;
   import tmr_pkg::*;

   localparam logic [2:0] CMD_UNUSED = 3'd7;

   typedef struct packed {
      logic [2:0]         kind;
      logic [3:0]         out_slot;
      logic               out_handle_valid;
      logic               active;
      logic signed [31:0] remaining;
      logic [7:0]         fire_count;
      logic               no_free_slot;
      logic               last;
   } word_type;

   class timer_scoreboard;
      bit          used [TMR_SLOTS];
      bit          lp [TMR_SLOTS];
      logic [30:0] period [TMR_SLOTS];
      logic [31:0] left [TMR_SLOTS];
      logic [7:0]  own [TMR_SLOTS];
      word_type    pending [$];
      int          mismatches;

      function void push(logic [2:0] kind, logic [3:0] s, logic hv, logic act,
                         logic [31:0] rem, logic [7:0] cnt, logic nf);
         word_type w;
         w.kind = kind; w.out_slot = s; w.out_handle_valid = hv; w.active = act;
         w.remaining = rem; w.fire_count = cnt; w.no_free_slot = nf; w.last = 1'b0;
         pending = {pending, w};
      endfunction

      function void note_command(logic [2:0] cmd, logic hv, logic [3:0] s,
                                 logic [7:0] owner, logic [30:0] rate, logic looping,
                                 logic [31:0] fd, logic [30:0] delta);
         int n;
         logic [3:0] slot_sel;
         bit found;
         logic [31:0] r, p, k;
         n = 0;
         case (cmd)
            CMD_SET: begin
               if (rate == '0) begin
                  if (hv) used[s] = 1'b0;
                  push(KIND_SET_ACK, s, 1'b0, 1'b0, 32'd0, 8'd0, 1'b0);
               end else begin
                  found = hv;
                  slot_sel = s;
                  for (int i = 0; i < TMR_SLOTS && !found; i++)
                     if (!used[i]) begin
                        slot_sel = 4'(i);
                        found = 1'b1;
                     end
                  if (!found) push(KIND_SET_ACK, 4'd0, 1'b0, 1'b0, 32'd0, 8'd0, 1'b1);
                  else begin
                     used[slot_sel] = 1'b1; lp[slot_sel] = looping;
                     period[slot_sel] = rate; own[slot_sel] = owner;
                     left[slot_sel] = fd[31] ? {1'b0, rate} : fd;
                     push(KIND_SET_ACK, slot_sel, 1'b1, 1'b0, 32'd0, 8'd0, 1'b0);
                  end
               end
               n = 1;
            end
            CMD_CLEAR: begin
               if (hv) used[s] = 1'b0;
               push(KIND_CLR_ACK, s, 1'b0, 1'b0, 32'd0, 8'd0, 1'b0);
               n = 1;
            end
            CMD_QUERY: begin
               if (hv && used[s]) push(KIND_QUERY, s, 1'b1, 1'b1, left[s], 8'd0, 1'b0);
               else push(KIND_QUERY, s, hv, 1'b0, 32'hFFFF_FFFF, 8'd0, 1'b0);
               n = 1;
            end
            CMD_TICK: begin
               if (delta != '0)
                  for (int i = 0; i < TMR_SLOTS; i++) begin
                     if (!used[i]) continue;
                     if (left[i] > {1'b0, delta}) begin
                        left[i] = left[i] - {1'b0, delta};
                        continue;
                     end
                     if (lp[i]) begin
                        p = (period[i] == '0) ? 32'd1 : {1'b0, period[i]};
                        r = {1'b0, delta} - left[i];
                        k = r / p + 32'd1;
                        left[i] = p - (r % p);
                        if (k > 32'd255) k = 32'd255;
                        if (n < TMR_MAX_RESULTS) begin
                           push(KIND_FIRE, 4'(i), 1'b1, 1'b0, 32'd0, k[7:0], 1'b0);
                           n++;
                        end
                     end else begin
                        used[i] = 1'b0;
                        if (n < TMR_MAX_RESULTS) begin
                           push(KIND_FIRE, 4'(i), 1'b0, 1'b0, 32'd0, 8'd1, 1'b0);
                           n++;
                        end
                     end
                  end
               if (n == 0) begin
                  push(KIND_NO_FIRE, 4'd0, 1'b0, 1'b0, 32'd0, 8'd0, 1'b0);
                  n = 1;
               end
            end
            CMD_CLR_OWNER: begin
               if (owner != '0)
                  for (int i = 0; i < TMR_SLOTS; i++)
                     if (used[i] && own[i] == owner) used[i] = 1'b0;
               push(KIND_CLR_ACK, 4'd0, 1'b0, 1'b0, 32'd0, 8'd0, 1'b0);
               n = 1;
            end
            default: ;
         endcase
         if (n > 0) pending[$].last = 1'b1;
      endfunction

      function void check_word(word_type got);
         word_type w;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word kind=%0d slot=%0d",
                                           got.kind, got.out_slot);
            return;
         end
         w = pending.pop_front();
         if (got !== w) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch exp k%0d s%0d hv%0d a%0d r%0d c%0d nf%0d l%0d",
                        w.kind, w.out_slot, w.out_handle_valid, w.active, w.remaining,
                        w.fire_count, w.no_free_slot, w.last);
               $display("         got k%0d s%0d hv%0d a%0d r%0d c%0d nf%0d l%0d",
                        got.kind, got.out_slot, got.out_handle_valid, got.active,
                        got.remaining, got.fire_count, got.no_free_slot, got.last);
            end
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic [2:0]         req_cmd = 0;
   logic               req_handle_valid = 0;
   logic [3:0]         req_slot = 0;
   logic [7:0]         req_owner = 0;
   logic [30:0]        req_rate = 0;
   logic               req_looping = 0;
   logic signed [31:0] req_first_delay = 0;
   logic [30:0]        req_delta = 0;
   logic               rsp_strobe;
   logic [2:0]         rsp_kind;
   logic [3:0]         rsp_out_slot;
   logic               rsp_out_handle_valid;
   logic               rsp_active;
   logic signed [31:0] rsp_remaining;
   logic [7:0]         rsp_fire_count;
   logic               rsp_no_free_slot;
   logic               rsp_last;

   timer_scoreboard sb;
   int idle_pct;
   int cycles = 0;

   multi_slot_software_timer_table_unit u_dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // result words are checked at the edge that ends their cycle
   always @(posedge clock) begin
      word_type got;
      if (!reset && rsp_strobe) begin
         got.kind = rsp_kind; got.out_slot = rsp_out_slot;
         got.out_handle_valid = rsp_out_handle_valid; got.active = rsp_active;
         got.remaining = rsp_remaining; got.fire_count = rsp_fire_count;
         got.no_free_slot = rsp_no_free_slot; got.last = rsp_last;
         sb.check_word(got);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // drive one command word and hold it until the block takes it;
   // start stays high afterwards so back-to-back words need no gap
   task automatic send(logic [2:0] cmd, logic hv, logic [3:0] s, logic [7:0] owner,
                       logic [30:0] rate, logic looping, logic [31:0] fd,
                       logic [30:0] delta);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      start <= 1'b1; req_cmd <= cmd; req_handle_valid <= hv; req_slot <= s;
      req_owner <= owner; req_rate <= rate; req_looping <= looping;
      req_first_delay <= fd; req_delta <= delta;
      // busy is stable at the falling edge
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      sb.note_command(cmd, hv, s, owner, rate, looping, fd, delta);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_random();
      int pick;
      logic [30:0] small_t;
      logic [31:0] fd_r;
      pick = $urandom_range(99);
      small_t = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(60, 1));
      fd_r = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(80));
      if (pick < 35)
         send(CMD_SET, 1'($urandom_range(1)), 4'($urandom),
              ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3)),
              ($urandom_range(15) == 0) ? 31'd0 : small_t, 1'($urandom), fd_r, 31'd0);
      else if (pick < 45)
         send(CMD_CLEAR, 1'($urandom), 4'($urandom), 8'd0, 31'd0, 1'b0, 32'd0, 31'd0);
      else if (pick < 65)
         send(CMD_QUERY, 1'($urandom), 4'($urandom), 8'd0, 31'd0, 1'b0, 32'd0, 31'd0);
      else if (pick < 90)
         send(CMD_TICK, 1'b0, 4'd0, 8'd0, 31'd0, 1'b0, 32'd0,
              ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(40)));
      else if (pick < 96)
         send(CMD_CLR_OWNER, 1'b0, 4'd0, 8'($urandom_range(3)), 31'd0, 1'b0, 32'd0,
              31'd0);
      else
         send(3'($urandom_range(7, 5)), 1'($urandom), 4'($urandom), 8'($urandom),
              31'($urandom), 1'($urandom), $urandom, 31'($urandom));
   endtask

   initial begin
      sb = new();
      idle_pct = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, no free slot, zero rate, negative first delay
      send(CMD_TICK, 1'b0, 4'd0, 8'd0, 31'd0, 1'b0, 32'd0, 31'd0);
      send(CMD_QUERY, 1'b1, 4'd15, 8'd0, 31'd0, 1'b0, 32'd0, 31'd0);
      send(CMD_QUERY, 1'b0, 4'd3, 8'd0, 31'd0, 1'b0, 32'd0, 31'd0);
      for (int i = 0; i < 16; i++)
         send(CMD_SET, 1'b0, 4'd0, 8'(i) | 8'h80, 31'(i + 1), 1'(i), 32'hFFFF_FFFF, 31'd0);
      send(CMD_SET, 1'b0, 4'd0, 8'd1, 31'd5, 1'b0, 32'd5, 31'd0);
      send(CMD_SET, 1'b1, 4'd15, 8'hFF, 31'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 31'd0);
      send(CMD_QUERY, 1'b1, 4'd15, 8'd0, 31'd0, 1'b0, 32'd0, 31'd0);
      send(CMD_TICK, 1'b0, 4'd0, 8'd0, 31'd0, 1'b0, 32'd0, 31'd1000);
      send(CMD_TICK, 1'b0, 4'd0, 8'd0, 31'd0, 1'b0, 32'd0, 31'h7FFF_FFFF);
      send(CMD_SET, 1'b1, 4'd2, 8'd0, 31'd0, 1'b0, 32'd0, 31'd0);
      send(CMD_CLR_OWNER, 1'b0, 4'd0, 8'h81, 31'd0, 1'b0, 32'd0, 31'd0);
      send(CMD_CLR_OWNER, 1'b0, 4'd0, 8'd0, 31'd0, 1'b0, 32'd0, 31'd0);
      send(CMD_CLEAR, 1'b1, 4'd1, 8'd0, 31'd0, 1'b0, 32'd0, 31'd0);
      send(CMD_UNUSED, 1'b1, 4'd0, 8'd0, 31'd0, 1'b0, 32'd0, 31'd0);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 62 : (ph == 3) ? 19 : 0;
         repeat (65) send_random();
         drain();
      end
      if (sb.mismatches == 0 && sb.pending.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
